// ===== design/psw_pkg.sv =====
// Shared types and field widths for the priority schedule wait-time block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package psw_pkg;

   localparam int ID_W    = 16;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int WAIT_W  = 22;
   localparam int TOTAL_W = 28;
   localparam int COUNT_W = 7;

   // One stored process: identifier, burst and priority
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   // Sequencer commands to the selection unit
   typedef struct packed {
      logic clear;       // drop all served marks (batch done)
      logic start;       // begin a new selection scan
      logic cand_valid;  // a table entry is presented this cycle
      logic mark;        // mark the current best as served
   } scan_ctl_type;

   // One result as held in the output register
   typedef struct packed {
      logic [ID_W-1:0]    out_process_id;
      logic [BURST_W-1:0] out_burst_time;
      logic [PRIO_W-1:0]  out_priority;
      logic [WAIT_W-1:0]  waiting_time;
      logic [WAIT_W-1:0]  turnaround_time;
      logic [TOTAL_W-1:0] total_waiting;
      logic [TOTAL_W-1:0] total_turnaround;
      logic [COUNT_W-1:0] process_count;
      logic               batch_overflow;
      logic               last_result;
   } result_type;

endpackage

`default_nettype wire

// ===== design/psw_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
// Depends on psw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface psw_req_if;
   import psw_pkg::*;

   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    process_id;
   logic [BURST_W-1:0] burst_time;
   logic [PRIO_W-1:0]  priority_level;
   logic               last_in_batch;

   modport source (output valid, output process_id, output burst_time,
                   output priority_level, output last_in_batch, input ready);
   modport sink   (input valid, input process_id, input burst_time,
                   input priority_level, input last_in_batch, output ready);
endinterface

interface psw_rsp_if;
   import psw_pkg::*;

   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    out_process_id;
   logic [BURST_W-1:0] out_burst_time;
   logic [PRIO_W-1:0]  out_priority;
   logic [WAIT_W-1:0]  waiting_time;
   logic [WAIT_W-1:0]  turnaround_time;
   logic [TOTAL_W-1:0] total_waiting;
   logic [TOTAL_W-1:0] total_turnaround;
   logic [COUNT_W-1:0] process_count;
   logic               batch_overflow;
   logic               last_result;

   modport source (output valid, output out_process_id, output out_burst_time,
                   output out_priority, output waiting_time, output turnaround_time,
                   output total_waiting, output total_turnaround, output process_count,
                   output batch_overflow, output last_result, input ready);
   modport sink   (input valid, input out_process_id, input out_burst_time,
                   input out_priority, input waiting_time, input turnaround_time,
                   input total_waiting, input total_turnaround, input process_count,
                   input batch_overflow, input last_result, output ready);
endinterface

`default_nettype wire

// ===== design/psw_table.sv =====
// Process table: one write port, one read port with registered read data.
// Depends on psw_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module psw_table #(
   parameter int DEPTH = 64,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  psw_pkg::entry_type  wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output psw_pkg::entry_type  rd_data
);
   import psw_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/psw_scan.sv =====
// Selection unit: a shared priority comparator fed one table entry a cycle,
// keeping the earliest unserved entry of highest priority. Depends on psw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psw_scan #(
   parameter int DEPTH = 64,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  psw_pkg::scan_ctl_type ctl,
   input  logic [IDX_W-1:0]      cand_idx,
   input  psw_pkg::entry_type    cand,
   output psw_pkg::entry_type    best,
   output logic [IDX_W-1:0]      best_idx,
   output logic                  found
);
   import psw_pkg::*;

   logic [DEPTH-1:0] done_ff;
   logic             have_ff;
   entry_type        best_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic             take;

   // strict compare: on equal priority the earlier index stays
   assign take = ctl.cand_valid && !done_ff[cand_idx] &&
                 (!have_ff || (cand.prio > best_ff.prio));

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         done_ff <= '0;
      end else begin
         if (ctl.start) begin
            have_ff <= 1'b0;
         end else if (take) begin
            have_ff <= 1'b1;
         end
         if (ctl.clear) begin
            done_ff <= '0;
         end else if (ctl.mark) begin
            done_ff[best_idx_ff] <= 1'b1;
         end
      end
      if (take) begin
         best_ff     <= cand;
         best_idx_ff <= cand_idx;
      end
   end

   assign best     = best_ff;
   assign best_idx = best_idx_ff;
   assign found    = have_ff;

endmodule

`default_nettype wire

// ===== design/priority_schedule_wait_times.sv =====
// Top level of the non-preemptive priority scheduler: sequencer, wait/turnaround
// accumulation and output register. Uses psw_pkg, psw_if, psw_table, psw_scan.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake    Moves
// req_ch    in   valid/ready  one process request: id, burst, priority, last flag
// rsp_ch    out  valid/ready  one scheduled process with wait, turnaround, totals
//
// Flow: requests load at one per cycle while loading. After the request marked last,
// a batch of n processes yields n results; each comes from a full pass of table
// reads through the single read port into the shared comparator, a read latency
// drain, then issue of the result once the output register is free.
// Reset: synchronous; clears the fill count, overflow flag, served marks and
// the output valid flag. The table itself holds no reset value.
// Stalls: req_ch.ready is high only while loading; a stalled result holds the
// sequencer before the next scan, and loading resumes once the last result
// sits in the output register.

module priority_schedule_wait_times #(
   parameter int MAX_PROCESSES = 64
) (
   input  logic      clock,
   input  logic      reset,
   psw_req_if.sink   req_ch,
   psw_rsp_if.source rsp_ch
);
   import psw_pkg::*;

   localparam int IDX_W = $clog2(MAX_PROCESSES);
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_PROCESSES);

   typedef enum logic [1:0] {S_LOAD, S_SCAN, S_DRAIN, S_RESULT} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] cand_idx_ff, cand_idx_in;
   logic [CNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic [TOTAL_W-1:0] tot_w_ff, tot_w_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic             req_acc;
   logic             rsp_free;
   logic             wr_en;
   entry_type        wr_data;
   entry_type        rd_data;
   logic             rd_last;
   logic             res_last;
   logic             emit;
   logic [WAIT_W-1:0]  tat;
   logic [TOTAL_W-1:0] tot_w_sum;
   logic [TOTAL_W-1:0] tot_t_sum;

   scan_ctl_type     scan_ctl;
   entry_type        best;
   logic [IDX_W-1:0] best_idx;
   logic             scan_found;

   assign req_ch.ready = (state_ff == S_LOAD);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // store while there is room; beyond capacity drop and flag
   assign wr_en   = req_acc && (count_ff != CAP);
   assign wr_data = '{id: req_ch.process_id, burst: req_ch.burst_time,
                      prio: req_ch.priority_level};

   assign rd_last  = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);
   assign res_last = ((emit_cnt_ff + CNT_W'(1)) == count_ff);
   assign emit     = (state_ff == S_RESULT) && rsp_free;

   // turnaround and running totals for the process now at the head
   assign tat       = wait_ff + WAIT_W'(best.burst);
   assign tot_w_sum = tot_w_ff + TOTAL_W'(wait_ff);
   assign tot_t_sum = tot_w_sum + TOTAL_W'(tat);

   assign scan_ctl.clear      = emit && res_last;
   assign scan_ctl.start      = (req_acc && req_ch.last_in_batch) || (emit && !res_last);
   assign scan_ctl.cand_valid = rd_valid_ff;
   assign scan_ctl.mark       = emit;

   psw_table #(.DEPTH(MAX_PROCESSES), .IDX_W(IDX_W)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   psw_scan #(.DEPTH(MAX_PROCESSES), .IDX_W(IDX_W)) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .cand_idx (cand_idx_ff),
      .cand     (rd_data),
      .best     (best),
      .best_idx (best_idx),
      .found    (scan_found)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rd_idx_in    = rd_idx_ff;
      rd_valid_in  = (state_ff == S_SCAN);
      cand_idx_in  = rd_idx_ff;
      emit_cnt_in  = emit_cnt_ff;
      wait_in      = wait_ff;
      tot_w_in     = tot_w_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               // last request closes the batch, dropped or not
               if (req_ch.last_in_batch) begin
                  rd_idx_in = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // advance the read pointer over the batch
            rd_idx_in = rd_idx_ff + IDX_W'(1);
            if (rd_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.out_process_id   = best.id;
               rsp_data_in.out_burst_time   = best.burst;
               rsp_data_in.out_priority     = best.prio;
               rsp_data_in.waiting_time     = wait_ff;
               rsp_data_in.turnaround_time  = tat;
               rsp_data_in.total_waiting    = res_last ? tot_w_sum : '0;
               rsp_data_in.total_turnaround = res_last ? tot_t_sum : '0;
               rsp_data_in.process_count    = COUNT_W'(count_ff);
               rsp_data_in.batch_overflow   = ovf_ff;
               rsp_data_in.last_result      = res_last;
               if (res_last) begin
                  // batch done: drop the bookkeeping, reopen for loading
                  count_in    = '0;
                  ovf_in      = 1'b0;
                  emit_cnt_in = '0;
                  wait_in     = '0;
                  tot_w_in    = '0;
                  state_in    = S_LOAD;
               end else begin
                  emit_cnt_in = emit_cnt_ff + CNT_W'(1);
                  wait_in     = tat;
                  tot_w_in    = tot_w_sum;
                  rd_idx_in   = '0;
                  state_in    = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_idx_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         cand_idx_ff  <= '0;
         emit_cnt_ff  <= '0;
         wait_ff      <= '0;
         tot_w_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rd_idx_ff    <= rd_idx_in;
         rd_valid_ff  <= rd_valid_in;
         cand_idx_ff  <= cand_idx_in;
         emit_cnt_ff  <= emit_cnt_in;
         wait_ff      <= wait_in;
         tot_w_ff     <= tot_w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.out_process_id   = rsp_data_ff.out_process_id;
   assign rsp_ch.out_burst_time   = rsp_data_ff.out_burst_time;
   assign rsp_ch.out_priority     = rsp_data_ff.out_priority;
   assign rsp_ch.waiting_time     = rsp_data_ff.waiting_time;
   assign rsp_ch.turnaround_time  = rsp_data_ff.turnaround_time;
   assign rsp_ch.total_waiting    = rsp_data_ff.total_waiting;
   assign rsp_ch.total_turnaround = rsp_data_ff.total_turnaround;
   assign rsp_ch.process_count    = rsp_data_ff.process_count;
   assign rsp_ch.batch_overflow   = rsp_data_ff.batch_overflow;
   assign rsp_ch.last_result      = rsp_data_ff.last_result;

   // a result is issued only after the scan has picked an unserved entry
   a_found_on_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT) |-> scan_found)
      else $error("result issued with no selected entry");

   // the selected entry always lies inside the loaded batch
   a_best_in_batch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT) |-> (CNT_W'(best_idx) < count_ff))
      else $error("selected entry outside batch");

   // scheduling never runs past the batch, and a batch is never empty
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> ((emit_cnt_ff < count_ff) && (count_ff != '0)))
      else $error("emit count outside batch");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("fill count above capacity");

   // turnaround is always wait plus own burst
   a_tat_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.turnaround_time ==
                        (rsp_data_ff.waiting_time + WAIT_W'(rsp_data_ff.out_burst_time))))
      else $error("turnaround does not match wait plus burst");

   a_totals_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last_result) |->
         (rsp_data_ff.total_turnaround >= rsp_data_ff.total_waiting))
      else $error("total turnaround below total waiting");

endmodule

`default_nettype wire

// ===== tb/priority_schedule_wait_times_tb.sv =====
// Testbench for priority_schedule_wait_times: drives process requests, predicts
// the service order with wait and turnaround times, and checks every result.
// Depends on psw_pkg, psw_if and the block under test.
`timescale 1ns / 1ps

module priority_schedule_wait_times_tb;
   import psw_pkg::*;

   localparam int MAX_PROCESSES = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIRECTED_ROWS = 15;
   localparam int RANDOM_ITEMS  = 255;
   localparam int SHOW_LIMIT    = 10;

   // One request as the sender sees it. A pinned result is typed in by hand and
   // replaces the predicted one; only single-process batches carry it.
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic               last;
      logic               drain_first;
      logic               has_pinned;
      result_type         pinned;
   } sched_request_type;

   localparam result_type NOT_PINNED = '0;

   // Directed requests: extremes, ties, reversal, bit patterns
   sched_request_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // lone process at every field maximum
      '{16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b1,
        '{16'hFFFF, 16'hFFFF, 8'hFF, 22'd0, 22'd65535, 28'd0, 28'd65535, 7'd1, 1'b0, 1'b1}},
      // lone process at every field minimum
      '{16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b1,
        '{16'h0000, 16'h0000, 8'h00, 22'd0, 22'd0, 28'd0, 28'd0, 7'd1, 1'b0, 1'b1}},
      // mixed batch with equal priorities that must keep arrival order
      '{16'h0101, 16'd10,    8'd3,  1'b0, 1'b0, 1'b0, NOT_PINNED},
      '{16'h0202, 16'd20,    8'd7,  1'b0, 1'b0, 1'b0, NOT_PINNED},
      '{16'h0303, 16'd0,     8'd3,  1'b0, 1'b0, 1'b0, NOT_PINNED},
      '{16'h0404, 16'hFFFF,  8'd7,  1'b0, 1'b0, 1'b0, NOT_PINNED},
      '{16'h0505, 16'd5,     8'd0,  1'b1, 1'b0, 1'b0, NOT_PINNED},
      // two maximal bursts at the same lowest priority
      '{16'hBEEF, 16'hFFFF,  8'd0,  1'b0, 1'b0, 1'b0, NOT_PINNED},
      '{16'hCAFE, 16'hFFFF,  8'd0,  1'b1, 1'b0, 1'b0, NOT_PINNED},
      // ascending priorities, served fully reversed
      '{16'h0010, 16'd100,   8'd0,   1'b0, 1'b0, 1'b0, NOT_PINNED},
      '{16'h0020, 16'd200,   8'd128, 1'b0, 1'b0, 1'b0, NOT_PINNED},
      '{16'h0030, 16'd300,   8'd255, 1'b1, 1'b0, 1'b0, NOT_PINNED},
      // alternating bit patterns on every field
      '{16'hAAAA, 16'h5555,  8'h55, 1'b0, 1'b0, 1'b0, NOT_PINNED},
      '{16'h5555, 16'hAAAA,  8'hAA, 1'b1, 1'b0, 1'b0, NOT_PINNED},
      // lone process with a unit burst
      '{16'h1234, 16'd1,     8'd80, 1'b1, 1'b0, 1'b1,
        '{16'h1234, 16'd1, 8'd80, 22'd0, 22'd1, 28'd0, 28'd1, 7'd1, 1'b0, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   psw_req_if req_ch ();
   psw_rsp_if rsp_ch ();

   priority_schedule_wait_times #(
      .MAX_PROCESSES(MAX_PROCESSES)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Full request sequence, shared by the sender and the acceptance monitor
   sched_request_type request_q[$];
   int unsigned       accepted_count = 0;

   // Predictor state: the open batch and its drop flag
   entry_type   batch_table [MAX_PROCESSES];
   int unsigned batch_fill = 0;
   logic        batch_dropped = 1'b0;

   // Results still owed by the block, oldest first
   result_type service_due_q[$];

   int unsigned fault_count = 0;
   int unsigned shown_faults = 0;
   int unsigned cycle_count = 0;
   bit          quiet = 1'b0;

   // Store one request into the open batch; on the closing request, order the
   // batch by descending priority (stable) and queue one result per process.
   function automatic void predict_service(sched_request_type row);
      entry_type          order [MAX_PROCESSES];
      entry_type          held;
      int                 n;
      int                 j;
      logic [WAIT_W-1:0]  start_at;
      logic [WAIT_W-1:0]  finish_at;
      logic [TOTAL_W-1:0] sum_wait;
      logic [TOTAL_W-1:0] sum_turn;
      result_type         res;

      if (batch_fill < MAX_PROCESSES) begin
         batch_table[batch_fill] = '{row.id, row.burst, row.prio};
         batch_fill++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (!row.last) return;

      n = batch_fill;
      for (int i = 0; i < n; i++) order[i] = batch_table[i];
      // insertion sort: only a strictly lower priority moves down, so ties hold
      for (int i = 1; i < n; i++) begin
         held = order[i];
         j = i;
         while (j > 0 && order[j-1].prio < held.prio) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = held;
      end

      start_at = '0;
      sum_wait = '0;
      sum_turn = '0;
      for (int k = 0; k < n; k++) begin
         finish_at = start_at + WAIT_W'(order[k].burst);
         sum_wait  = sum_wait + TOTAL_W'(start_at);
         sum_turn  = sum_turn + TOTAL_W'(finish_at);
         res.out_process_id   = order[k].id;
         res.out_burst_time   = order[k].burst;
         res.out_priority     = order[k].prio;
         res.waiting_time     = start_at;
         res.turnaround_time  = finish_at;
         res.total_waiting    = (k == n - 1) ? sum_wait : '0;
         res.total_turnaround = (k == n - 1) ? sum_turn : '0;
         res.process_count    = COUNT_W'(n);
         res.batch_overflow   = batch_dropped;
         res.last_result      = (k == n - 1);
         service_due_q = {service_due_q, res};
         start_at = finish_at;
      end
      batch_fill    = 0;
      batch_dropped = 1'b0;
   endfunction

   // Compare one result against the oldest owed one, field by field
   function automatic void check_result(result_type want, result_type got);
      string bad = "";

      if (got.out_process_id   !== want.out_process_id)   bad = {bad, " out_process_id"};
      if (got.out_burst_time   !== want.out_burst_time)   bad = {bad, " out_burst_time"};
      if (got.out_priority     !== want.out_priority)     bad = {bad, " out_priority"};
      if (got.waiting_time     !== want.waiting_time)     bad = {bad, " waiting_time"};
      if (got.turnaround_time  !== want.turnaround_time)  bad = {bad, " turnaround_time"};
      if (got.total_waiting    !== want.total_waiting)    bad = {bad, " total_waiting"};
      if (got.total_turnaround !== want.total_turnaround) bad = {bad, " total_turnaround"};
      if (got.process_count    !== want.process_count)    bad = {bad, " process_count"};
      if (got.batch_overflow   !== want.batch_overflow)   bad = {bad, " batch_overflow"};
      if (got.last_result      !== want.last_result)      bad = {bad, " last_result"};
      if (bad != "") begin
         fault_count++;
         if (shown_faults < SHOW_LIMIT) begin
            shown_faults++;
            $display("[%0t] mismatch in%s", $realtime, bad);
            $display("   expected %p", want);
            $display("   actual   %p", got);
         end
      end
   endfunction

   // Random request content; a batch-wide mode makes ties or extremes likely
   function automatic sched_request_type random_request(int prio_mode, bit last);
      sched_request_type row;

      row             = '0;
      row.id          = ID_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 7))
         0:       row.burst = '0;
         1:       row.burst = '1;
         default: row.burst = BURST_W'($urandom_range(0, 65535));
      endcase
      case (prio_mode)
         0:       row.prio = PRIO_W'($urandom_range(0, 3));
         1:       row.prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: row.prio = PRIO_W'($urandom_range(0, 255));
      endcase
      row.last        = last;
      row.drain_first = 1'b0;
      row.has_pinned  = 1'b0;
      row.pinned      = NOT_PINNED;
      return row;
   endfunction

   // Run limit: any hang ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Watch the request side: every accepted request feeds the predictor
   always @(posedge clock) begin : watch_requests
      sched_request_type row;
      if (!reset && req_ch.valid && req_ch.ready) begin
         row = request_q[accepted_count];
         accepted_count++;
         predict_service(row);
         // swap the predicted result of a hand-checked row for the typed one
         if (row.has_pinned) begin
            void'(service_due_q.pop_back());
            service_due_q = {service_due_q, row.pinned};
         end
      end
   end

   // Watch the result side: check each accepted result against the oldest owed
   always @(posedge clock) begin : watch_results
      result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.out_process_id, rsp_ch.out_burst_time, rsp_ch.out_priority,
                 rsp_ch.waiting_time, rsp_ch.turnaround_time, rsp_ch.total_waiting,
                 rsp_ch.total_turnaround, rsp_ch.process_count, rsp_ch.batch_overflow,
                 rsp_ch.last_result};
         if (service_due_q.size() == 0) begin
            fault_count++;
            if (shown_faults < SHOW_LIMIT) begin
               shown_faults++;
               $display("[%0t] result with nothing owed: %p", $realtime, got);
            end
         end else begin
            check_result(service_due_q.pop_front(), got);
         end
      end
   end

   // Result receiver: hold ready low in random bursts, never once quiet
   initial begin
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // Request sender: build the whole sequence, then drive it
   initial begin : send_requests
      int                batch_no;
      int                random_sent;
      int                n;
      int                prio_mode;
      int                gap;
      int                quiet_from;
      sched_request_type row;

      req_ch.valid          <= 1'b0;
      req_ch.process_id     <= '0;
      req_ch.burst_time     <= '0;
      req_ch.priority_level <= '0;
      req_ch.last_in_batch  <= 1'b0;

      // Walk the directed table first
      for (int i = 0; i < DIRECTED_ROWS; i++) request_q = {request_q, directed_rows[i]};

      // Random batches: mostly short ones, plus one full batch of maximal bursts
      // and one batch that runs past capacity and closes on a dropped request
      batch_no    = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         prio_mode = $urandom_range(0, 2);
         if (batch_no == 3) n = MAX_PROCESSES;
         else if (batch_no == 7) n = MAX_PROCESSES + $urandom_range(2, 6);
         else if ($urandom_range(0, 7) == 0) n = $urandom_range(9, 20);
         else n = $urandom_range(1, 8);
         for (int k = 0; k < n; k++) begin
            row = random_request(prio_mode, k == n - 1);
            if (batch_no == 3) row.burst = '1;
            // let the previous batch finish before the two long ones
            if (k == 0 && (batch_no == 3 || batch_no == 7)) row.drain_first = 1'b1;
            request_q = {request_q, row};
         end
         random_sent += n;
         batch_no++;
      end
      quiet_from = request_q.size() * 85 / 100;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < request_q.size(); i++) begin
         row = request_q[i];
         if (i >= quiet_from) quiet = 1'b1;
         gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
         if (row.drain_first || gap != 0) begin
            req_ch.valid <= 1'b0;
            if (row.drain_first) begin
               do @(posedge clock); while (service_due_q.size() != 0);
            end
            repeat (gap) @(posedge clock);
         end
         req_ch.valid          <= 1'b1;
         req_ch.process_id     <= row.id;
         req_ch.burst_time     <= row.burst;
         req_ch.priority_level <= row.prio;
         req_ch.last_in_batch  <= row.last;
         do @(posedge clock); while (!req_ch.ready);
      end
      req_ch.valid <= 1'b0;

      // Drain every owed result, then watch a while for strays
      do @(posedge clock); while (service_due_q.size() != 0);
      repeat (200) @(posedge clock);

      if (service_due_q.size() != 0) begin
         fault_count += service_due_q.size();
         $display("%0d results never arrived", service_due_q.size());
      end
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
